/* rtl/core/pil_pkg.sv */
// Package for the position indexed list: sizes, request/response structs,
// operation and status codes, and the control word broadcast to the cells.
// No dependencies.
package pil_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_LOCATE = 2'd1,
    OP_INSERT = 2'd2,
    OP_DELETE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INDEX    = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [7:0]               position;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]               status;
    logic signed [DATA_W-1:0] data_out;
    logic [4:0]               found_position;
    logic [4:0]               list_length;
  } rsp_t;

  typedef struct packed {
    logic              ins;
    logic              del;
    logic [IDX_W-1:0]  base;
    logic [DATA_W-1:0] value;
    logic [CNT_W-1:0]  count;
  } cell_ctl_t;

endpackage

/* rtl/core/pil_cell.sv */
// One list cell: holds one entry, shifts to/from its neighbors on insert
// and delete, and flags a match against the locate value.
// Depends on pil_pkg.
module pil_cell (
  input  logic                       clk,
  input  logic [pil_pkg::IDX_W-1:0]  idx,
  input  pil_pkg::cell_ctl_t         ctl,
  input  logic [pil_pkg::DATA_W-1:0] left_data,
  input  logic [pil_pkg::DATA_W-1:0] right_data,
  output logic [pil_pkg::DATA_W-1:0] data_o,
  output logic                       match_o
);
  import pil_pkg::*;

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins) begin
      if (idx == ctl.base) begin
        data_nxt = ctl.value;
      end else if (idx > ctl.base) begin
        data_nxt = left_data;
      end
    end else if (ctl.del) begin
      if (idx >= ctl.base) begin
        data_nxt = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o  = data_r;
  assign match_o = (CNT_W'(idx) < ctl.count) && (data_r == ctl.value);

endmodule

/* rtl/core/position_indexed_list_top.sv */
// Top level of the position indexed list: request decode, row of cells,
// count register and registered response. Depends on pil_pkg, pil_cell.
// All cells shift or compare in parallel. The response is registered, valid
// in the cycle after accept; one request per cycle while out_ready is high.
// Reset: synchronous active-low rst_n clears the entry count and the
// response valid; cell contents are undefined until inserted.
module position_indexed_list_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  pil_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output pil_pkg::rsp_t out_data
);
  import pil_pkg::*;

  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0] cell_match;
  cell_ctl_t ctl;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  rsp_t             out_data_r;
  rsp_t             rsp;
  logic             accept;
  logic [8:0]       pos_ext, cnt_ext;
  logic             pos_in_list;
  logic [IDX_W-1:0] base;
  logic [DATA_W-1:0] sel_data;
  logic [CNT_W-1:0] found;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign pos_ext     = {1'b0, in_data.position};
  assign cnt_ext     = 9'(count_r);
  assign pos_in_list = (pos_ext != 9'd0) && (pos_ext <= cnt_ext);
  assign base        = IDX_W'(in_data.position - 8'd1);
  assign sel_data    = cell_data[base];

  always_comb begin
    found = '0;
    for (int k = CAPACITY - 1; k >= 0; k--) begin
      if (cell_match[k]) begin
        found = CNT_W'(k + 1);
      end
    end
  end

  always_comb begin
    rsp                = '0;
    count_nxt          = count_r;
    ctl                = '0;
    ctl.base           = base;
    ctl.value          = in_data.value;
    ctl.count          = count_r;
    case (in_data.req_type)
      OP_GET: begin
        if (pos_in_list) begin
          rsp.data_out = sel_data;
        end else begin
          rsp.status = ST_INDEX;
        end
      end
      OP_LOCATE: begin
        if (found != '0) begin
          rsp.found_position = 5'(found);
        end else begin
          rsp.status = ST_NOTFOUND;
        end
      end
      OP_INSERT: begin
        if (pos_ext == 9'd0 || pos_ext > cnt_ext + 9'd1) begin
          rsp.status = ST_INDEX;
        end else if (count_r == CNT_W'(CAPACITY)) begin
          rsp.status = ST_FULL;
        end else begin
          ctl.ins   = accept;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      default: begin
        if (count_r == '0) begin
          rsp.status = ST_EMPTY;
        end else if (!pos_in_list) begin
          rsp.status = ST_INDEX;
        end else begin
          rsp.data_out = sel_data;
          ctl.del      = accept;
          count_nxt    = count_r - CNT_W'(1);
        end
      end
    endcase
    rsp.list_length = 5'(count_nxt);
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_d, right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end
    pil_cell u_cell (
      .clk       (clk),
      .idx       (IDX_W'(i)),
      .ctl       (ctl),
      .left_data (left_d),
      .right_data(right_d),
      .data_o    (cell_data[i]),
      .match_o   (cell_match[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= rsp;
    end
  end

endmodule
